// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dq_pkg.sv =====
package dq_pkg;

    localparam int CNT_W  = 7;
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_LIST       = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_LIST
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_PUSH_F,
        CMD_PUSH_B,
        CMD_POP_F,
        CMD_POP_B,
        CMD_POP_DONE,
        CMD_LIST_START,
        CMD_LIST_STEP,
        CMD_EMPTY,
        CMD_IGNORE
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic list_end;
    } t_dp_status;

endpackage

// ===== rtl/dq_ctrl.sv =====
`include "assert_macros.svh"

module dq_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dq_pkg::OP_W-1:0]       i_op,
    input  dq_pkg::t_dp_status            i_dp_status,
    output dq_pkg::t_cmd                  o_cmd,
    output logic                          o_busy
);
    import dq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        o_busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    case (i_op)
                        OP_PUSH_FRONT: o_cmd = CMD_PUSH_F;
                        OP_PUSH_BACK:  o_cmd = CMD_PUSH_B;
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (i_dp_status.empty) begin
                                o_cmd = CMD_EMPTY;
                            end else begin
                                o_cmd   = (i_op == OP_POP_FRONT) ? CMD_POP_F : CMD_POP_B;
                                n_state = S_POP;
                            end
                        end
                        OP_LIST: begin
                            if (i_dp_status.empty) begin
                                o_cmd = CMD_EMPTY;
                            end else begin
                                o_cmd   = CMD_LIST_START;
                                n_state = S_LIST;
                            end
                        end
                        default: o_cmd = CMD_IGNORE;
                    endcase
                end
            end
            S_POP: begin
                o_cmd   = CMD_POP_DONE;
                n_state = S_IDLE;
            end
            S_LIST: begin
                o_cmd = CMD_LIST_STEP;
                if (i_dp_status.list_end) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `ASSERT_NEXT(a_pop_goes_busy, i_clk, i_rst_n,
        i_start && !o_busy && (i_op == OP_POP_FRONT || i_op == OP_POP_BACK) && !i_dp_status.empty,
        o_busy, "Pop on a non-empty deque did not wait for the read data.")

endmodule

// ===== rtl/dq_dpath.sv =====
`include "assert_macros.svh"

module dq_dpath #(
    parameter int DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dq_pkg::t_cmd                      i_cmd,
    input  logic signed [dq_pkg::DATA_W-1:0]  i_data_in,
    input  logic [dq_pkg::CNT_W-1:0]          i_capacity,
    output dq_pkg::t_dp_status                o_dp_status,
    output logic                              o_res_valid,
    output logic [dq_pkg::ST_W-1:0]           o_res_status,
    output logic signed [dq_pkg::DATA_W-1:0]  o_res_data,
    output logic                              o_res_last,
    output logic [dq_pkg::CNT_W-1:0]          o_res_occ
);
    import dq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int SW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;
    logic [AW-1:0]     r_head;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_lidx;
    logic              r_valid;
    logic [ST_W-1:0]   r_status;
    logic [DATA_W-1:0] r_data;
    logic              r_last;
    logic [CNT_W-1:0]  r_occ;

    logic [AW-1:0]     n_head;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  n_lidx;
    logic              n_valid;
    logic [ST_W-1:0]   n_status;
    logic [DATA_W-1:0] n_data;
    logic              n_last;

    logic [CNT_W-1:0]  offset;
    logic [SW-1:0]     sum_pos;
    logic [AW-1:0]     wrap_pos;
    logic [AW-1:0]     head_m1;
    logic              full;
    logic              list_end;
    logic              we;
    logic              re;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;

    always_comb begin
        case (i_cmd)
            CMD_POP_F:     offset = CNT_W'(1);
            CMD_POP_B:     offset = r_count - CNT_W'(1);
            CMD_PUSH_B:    offset = r_count;
            CMD_LIST_STEP: offset = r_lidx + CNT_W'(1);
            default:       offset = '0;
        endcase
    end

    // The head stays below DEPTH and the offset at most DEPTH, so one subtraction wraps the sum.
    assign sum_pos  = SW'(r_head) + SW'(offset);
    assign wrap_pos = (sum_pos >= SW'(DEPTH)) ? AW'(sum_pos - SW'(DEPTH)) : AW'(sum_pos);
    assign head_m1  = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign full     = (SW'(r_count) >= SW'(i_capacity)) || (SW'(r_count) >= SW'(DEPTH));
    assign list_end = ((r_lidx + CNT_W'(1)) == r_count);

    assign o_dp_status.empty    = (r_count == '0);
    assign o_dp_status.list_end = list_end;

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_lidx   = r_lidx;
        n_valid  = 1'b0;
        n_status = ST_OK;
        n_data   = '0;
        n_last   = 1'b1;
        we       = 1'b0;
        re       = 1'b0;
        waddr    = wrap_pos;
        raddr    = wrap_pos;
        case (i_cmd)
            CMD_PUSH_F: begin
                n_valid = 1'b1;
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    we      = 1'b1;
                    waddr   = head_m1;
                    n_head  = head_m1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_PUSH_B: begin
                n_valid = 1'b1;
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    we      = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_POP_F: begin
                re      = 1'b1;
                raddr   = r_head;
                n_head  = wrap_pos;
                n_count = r_count - CNT_W'(1);
            end
            CMD_POP_B: begin
                re      = 1'b1;
                n_count = r_count - CNT_W'(1);
            end
            CMD_POP_DONE: begin
                n_valid = 1'b1;
                n_data  = r_rdata;
            end
            CMD_LIST_START: begin
                re     = 1'b1;
                raddr  = r_head;
                n_lidx = '0;
            end
            CMD_LIST_STEP: begin
                n_valid = 1'b1;
                n_data  = r_rdata;
                n_last  = list_end;
                if (!list_end) begin
                    re     = 1'b1;
                    n_lidx = r_lidx + CNT_W'(1);
                end
            end
            CMD_EMPTY: begin
                n_valid  = 1'b1;
                n_status = ST_EMPTY;
            end
            CMD_IGNORE: n_valid = 1'b1;
            default: n_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= i_data_in;
        end
        if (re) begin
            r_rdata <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_lidx  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_lidx  <= n_lidx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_data   <= n_data;
        r_last   <= n_last;
        r_occ    <= n_count;
    end

    assign o_res_valid  = r_valid;
    assign o_res_status = r_status;
    assign o_res_data   = r_data;
    assign o_res_last   = r_last;
    assign o_res_occ    = r_occ;

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, SW'(r_count) <= SW'(DEPTH),
        "Entry count exceeds the store depth.")
    `ASSERT_NEXT(a_pop_count, i_clk, i_rst_n, i_cmd == CMD_POP_F || i_cmd == CMD_POP_B,
        r_count == $past(r_count) - CNT_W'(1), "Pop did not remove exactly one entry.")
    `ASSERT_NEXT(a_list_burst, i_clk, i_rst_n, r_valid && !r_last, r_valid,
        "Listing burst has a gap before its final beat.")

endmodule

// ===== rtl/double_ended_queue.sv =====
// Bounded double-ended queue of signed 32-bit words held in a circular store of DEPTH
// entries. A command is accepted when start is high and busy is low. Push, refused push,
// empty pop or listing, and unused op codes give their result beat in the cycle after the
// accept and leave busy low. A pop stays busy in S_POP as the store read is registered;
// its beat passes through r_rdata and the result registers. A listing of N entries keeps
// busy high in S_LIST and delivers N back-to-back beats the same way, the final one marked
// by o_last. Each result is on the outputs for exactly one cycle with o_valid high and must
// be taken then, as the receiver cannot stall. The capacity register is not clamped, but a
// push is also refused at DEPTH entries, and the store needs no clearing after reset.
module double_ended_queue #(
    parameter int DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [dq_pkg::OP_W-1:0]           i_op,
    input  logic signed [dq_pkg::DATA_W-1:0]  i_data_in,
    output logic                              o_valid,
    output logic [dq_pkg::ST_W-1:0]           o_status,
    output logic signed [dq_pkg::DATA_W-1:0]  o_data_out,
    output logic                              o_last,
    output logic [dq_pkg::CNT_W-1:0]          o_occupancy,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import dq_pkg::*;

    logic [CNT_W-1:0] r_capacity;
    t_cmd             cmd;
    t_dp_status       dp_status;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
            r_capacity <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == 1'b0) ? {{(32 - CNT_W){1'b0}}, r_capacity} : '0;

    dq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_op        (i_op),
        .i_dp_status (dp_status),
        .o_cmd       (cmd),
        .o_busy      (busy)
    );

    dq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_data_in    (i_data_in),
        .i_capacity   (r_capacity),
        .o_dp_status  (dp_status),
        .o_res_valid  (o_valid),
        .o_res_status (o_status),
        .o_res_data   (o_data_out),
        .o_res_last   (o_last),
        .o_res_occ    (o_occupancy)
    );

endmodule
